FILE: hdl/pmpt_pkg.sv
`timescale 1ns / 1ps

package pmpt_pkg;

	// packet byte phases
	localparam logic [1:0] PHASE_HDR = 2'd0;
	localparam logic [1:0] PHASE_DX  = 2'd1;
	localparam logic [1:0] PHASE_DY  = 2'd2;

	// header bit positions
	localparam int HDR_SYNC_BIT  = 3;
	localparam int HDR_XSIGN_BIT = 4;
	localparam int HDR_YSIGN_BIT = 5;
	localparam int HDR_BTN_W     = 3;

	localparam logic [15:0] RESET_X = 16'd512;
	localparam logic [15:0] RESET_Y = 16'd384;

	// request codes
	localparam logic FUNC_BYTE   = 1'b0;
	localparam logic FUNC_REPORT = 1'b1;

	typedef struct packed {
		logic signed [15:0]    pos_x;
		logic signed [15:0]    pos_y;
		logic [HDR_BTN_W-1:0]  button_bits;
		logic                  packet_done;
		logic signed [15:0]    delta_x;
		logic signed [15:0]    delta_y;
		logic                  moved;
	} pmpt_res_t;

	typedef struct packed {
		logic [1:0] phase;
		logic       moved;
	} pmpt_status_t;

	// sign-extend a mouse delta byte to 16 bits using its header sign bit
	function automatic logic [15:0] ext9(input logic [7:0] low, input logic neg);
		return {{8{neg}}, low};
	endfunction

endpackage

FILE: hdl/pmpt_if.sv
`timescale 1ns / 1ps

interface pmpt_req_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;

	modport source(output valid, func, data_byte, input ready);
	modport sink(input valid, func, data_byte, output ready);
endinterface

interface pmpt_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [2:0]         button_bits;
	logic               packet_done;
	logic signed [15:0] delta_x;
	logic signed [15:0] delta_y;
	logic               moved;

	modport source(output valid, pos_x, pos_y, button_bits, packet_done, delta_x, delta_y,
		moved, input ready);
	modport sink(input valid, pos_x, pos_y, button_bits, packet_done, delta_x, delta_y,
		moved, output ready);
endinterface

FILE: hdl/pmpt_tracker.sv
`timescale 1ns / 1ps

module pmpt_tracker import pmpt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic         func,
	input  logic [7:0]   data_byte,
	output pmpt_res_t    res,
	output pmpt_status_t status
);

	logic [1:0]           phase_q;
	logic [7:0]           header_q;
	logic [7:0]           dx_q;
	logic [15:0]          cur_x_q;
	logic [15:0]          cur_y_q;
	logic [HDR_BTN_W-1:0] buttons_q;
	logic [15:0]          rep_x_q;
	logic [15:0]          rep_y_q;

	logic [1:0]           phase_d;
	logic [7:0]           header_d;
	logic [7:0]           dx_d;
	logic [15:0]          cur_x_d;
	logic [15:0]          cur_y_d;
	logic [HDR_BTN_W-1:0] buttons_d;
	logic [15:0]          rep_x_d;
	logic [15:0]          rep_y_d;
	logic                 done;
	logic [15:0]          ddx;
	logic [15:0]          ddy;
	logic                 moved;

	assign moved = (cur_x_q != rep_x_q) || (cur_y_q != rep_y_q);

	always_comb begin
		phase_d   = phase_q;
		header_d  = header_q;
		dx_d      = dx_q;
		cur_x_d   = cur_x_q;
		cur_y_d   = cur_y_q;
		buttons_d = buttons_q;
		rep_x_d   = rep_x_q;
		rep_y_d   = rep_y_q;
		done      = 1'b0;
		ddx       = '0;
		ddy       = '0;
		if (func == FUNC_BYTE) begin
			unique case (phase_q)
				PHASE_DX: begin
					dx_d    = data_byte;
					phase_d = PHASE_DY;
				end
				PHASE_DY: begin
					buttons_d = header_q[HDR_BTN_W-1:0];
					cur_x_d   = cur_x_q + ext9(dx_q, header_q[HDR_XSIGN_BIT]);
					cur_y_d   = cur_y_q - ext9(data_byte, header_q[HDR_YSIGN_BIT]);
					phase_d   = PHASE_HDR;
					done      = 1'b1;
				end
				default: begin
					// header without sync bit is dropped
					if (data_byte[HDR_SYNC_BIT]) begin
						header_d = data_byte;
						phase_d  = PHASE_DX;
					end else begin
						phase_d = PHASE_HDR;
					end
				end
			endcase
		end else begin
			ddx     = cur_x_q - rep_x_q;
			ddy     = cur_y_q - rep_y_q;
			rep_x_d = cur_x_q;
			rep_y_d = cur_y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PHASE_HDR;
			header_q  <= '0;
			dx_q      <= '0;
			cur_x_q   <= RESET_X;
			cur_y_q   <= RESET_Y;
			buttons_q <= '0;
			rep_x_q   <= RESET_X;
			rep_y_q   <= RESET_Y;
		end else if (take) begin
			phase_q   <= phase_d;
			header_q  <= header_d;
			dx_q      <= dx_d;
			cur_x_q   <= cur_x_d;
			cur_y_q   <= cur_y_d;
			buttons_q <= buttons_d;
			rep_x_q   <= rep_x_d;
			rep_y_q   <= rep_y_d;
		end
	end

	assign res.pos_x       = cur_x_d;
	assign res.pos_y       = cur_y_d;
	assign res.button_bits = buttons_d;
	assign res.packet_done = done;
	assign res.delta_x     = ddx;
	assign res.delta_y     = ddy;
	assign res.moved       = moved;

	assign status.phase = phase_q;
	assign status.moved = moved;

endmodule

FILE: hdl/pmpt_out_reg.sv
`timescale 1ns / 1ps

module pmpt_out_reg import pmpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_ready,
	input  pmpt_res_t   src_data,
	pmpt_rsp_if.source  rsp
);

	logic      valid_q;
	pmpt_res_t data_q;

	// refill when empty or whenever the held result leaves in the same cycle
	assign src_ready = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (src_ready) begin
			valid_q <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			data_q <= src_data;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.pos_x       = data_q.pos_x;
	assign rsp.pos_y       = data_q.pos_y;
	assign rsp.button_bits = data_q.button_bits;
	assign rsp.packet_done = data_q.packet_done;
	assign rsp.delta_x     = data_q.delta_x;
	assign rsp.delta_y     = data_q.delta_y;
	assign rsp.moved       = data_q.moved;

endmodule

FILE: hdl/ps2_mouse_packet_tracker_core.sv
`timescale 1ns / 1ps

// channel  dir  fields
// -------  ---  ------------------------------------------------------------
// req      in   func, data_byte
// rsp      out  pos_x, pos_y, button_bits, packet_done, delta_x, delta_y, moved
//
// one transfer on req gives exactly one transfer on rsp through the result
// register; a new request is taken every cycle while the result register is
// empty or being drained, so the rate is one item per clock.
// reset puts the pointer at (512, 384), reported position equal, phase at header.
// a stalled rsp holds its result and blocks req until the result is taken.

module ps2_mouse_packet_tracker_core import pmpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pmpt_req_if.sink   req,
	pmpt_rsp_if.source rsp
);

	// request transfer
	logic         take;
	pmpt_res_t    res;
	pmpt_status_t status;

	assign take = req.valid && req.ready;

	// packet assembly and position state, result computed in the same cycle
	pmpt_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.func      (req.func),
		.data_byte (req.data_byte),
		.res       (res),
		.status    (status)
	);

	// result register decoupling the two sides
	pmpt_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (req.valid),
		.src_ready (req.ready),
		.src_data  (res),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	// after a report the reported position matches the current one
	a_report_syncs: assert property (@(posedge clk) disable iff (!arst_n)
		take && req.func == FUNC_REPORT |=> !status.moved)
		else $error("position still differs after report");

	// third packet byte always produces a completed-packet result
	a_packet_done: assert property (@(posedge clk) disable iff (!arst_n)
		take && req.func == FUNC_BYTE && status.phase == PHASE_DY
		|=> rsp.valid && rsp.packet_done)
		else $error("third byte did not complete a packet");

	// requests are only held off by a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid && !rsp.ready)
		else $error("request stalled without a pending result");

	// unused phase code never reached
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		status.phase == PHASE_HDR || status.phase == PHASE_DX || status.phase == PHASE_DY)
		else $error("illegal packet phase");
`endif

endmodule
